FILE: design/uec_pkg.sv
// shared types, constants and helper functions of the url escape canonicalizer
// no dependencies; every other design file but uec_if imports it
package uec_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [63:0] MASK_LOW_RST = 64'd8646911293074217213;
	localparam logic [31:0] MASK_HIGH_RST = 32'd2013265921;

	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CTRL_MAX = 8'h1F;
	localparam logic [7:0] HIGH_MIN = 8'h80;
	localparam logic [15:0] BYTE_MAX = 16'h00FF;

	typedef enum logic [1:0] {
		REG_UNICODE_MODE = 2'd0,
		REG_PERMIT_BAD = 2'd1,
		REG_MASK_LOW = 2'd2,
		REG_MASK_HIGH = 2'd3
	} reg_idx_t;

	// pending escape of the front end
	typedef enum logic [3:0] {
		ESC_NONE = 4'b0001,
		ESC_PCT = 4'b0010,
		ESC_HEX = 4'b0100,
		ESC_UNI = 4'b1000
	} esc_kind_t;

	// how the value of a command is written out after its replay prefix
	typedef enum logic [2:0] {
		TAIL_NONE = 3'd0,
		TAIL_PLAIN = 3'd1,
		TAIL_ESC = 3'd2,
		TAIL_WIDE = 3'd3,
		TAIL_PCT = 3'd4,
		TAIL_FAIL = 3'd5
	} tail_t;

	typedef struct packed {
		logic unicode_mode;
		logic permit_bad_escape;
		logic [63:0] unsafe_mask_low;
		logic [31:0] unsafe_mask_high;
	} cfg_t;

	// one command of the front end: optional '%' plus held bytes, then the tail
	typedef struct packed {
		logic pfx_en;
		logic [2:0] pfx_cnt;
		logic [3:0][7:0] pfx_bytes;
		tail_t tail;
		logic [15:0] value;
		logic last;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if (b inside {[8'h30:8'h39]}) begin
			d = b - CH_ZERO;
		end else if (b inside {[8'h61:8'h66]}) begin
			d = b - CH_LA + 8'd10;
		end else if (b inside {[8'h41:8'h46]}) begin
			d = b - CH_A + 8'd10;
		end
		return d[3:0];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + {4'h0, nib};
		end
		return CH_A - 8'd10 + {4'h0, nib};
	endfunction

endpackage

FILE: design/uec_if.sv
// valid/ready channel interfaces for the input bytes and the output characters
// no dependencies
interface uec_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface uec_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic out_last;
	logic out_error;

	modport source(output valid, output out_char, output out_last, output out_error, input ready);
	modport sink(input valid, input out_char, input out_last, input out_error, output ready);
endinterface

FILE: design/uec_front.sv
// front end: accepts raw bytes, tracks the pending escape and issues at most one command per byte
// depends on uec_pkg and uec_in_if
module uec_front (
	input logic clk,
	input logic arst_n,
	uec_in_if.sink in_ch,
	input uec_pkg::cfg_t cfg,
	output logic cmd_valid,
	input logic cmd_ready,
	output uec_pkg::cmd_t cmd
);
	import uec_pkg::*;

	esc_kind_t kind_q, kind_n;
	logic [2:0] cnt_q, cnt_n;
	logic [3:0][7:0] buf_q, buf_n;
	logic disc_q, disc_n;

	logic [7:0] b;
	logic last;
	logic b_hex;
	logic [3:0] b_val;
	logic brk;
	logic fail;
	logic accept;

	function automatic tail_t classify(input logic [15:0] v, input logic enc, input cfg_t c);
		logic uns;
		logic [6:0] idx;
		uns = 1'b0;
		idx = v[6:0] - 7'h20;
		if (v[7:0] inside {[8'h20:8'h5F]}) begin
			uns = c.unsafe_mask_low[idx[5:0]];
		end else if (v[7:0] inside {[8'h60:8'h7F]}) begin
			uns = c.unsafe_mask_high[v[4:0]];
		end
		if (v > BYTE_MAX) begin
			return TAIL_WIDE;
		end
		if (v[7:0] <= CTRL_MAX || v[7:0] >= HIGH_MIN || (enc && uns)) begin
			return TAIL_ESC;
		end
		return TAIL_PLAIN;
	endfunction

	assign b = in_ch.in_byte;
	assign last = in_ch.in_last;
	assign b_hex = is_hex(b);
	assign b_val = hex_val(b);
	assign in_ch.ready = cmd_ready;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd = '0;
		cmd.tail = TAIL_NONE;
		cmd.pfx_bytes = buf_q;
		cmd.value = {8'h00, b};
		cmd.last = last;
		kind_n = kind_q;
		cnt_n = cnt_q;
		buf_n = buf_q;
		disc_n = disc_q;
		brk = 1'b0;
		fail = 1'b0;
		if (disc_q) begin
			if (last) begin
				disc_n = 1'b0;
			end
		end else begin
			case (kind_q)
				ESC_NONE: begin
					if (b == CH_PCT) begin
						kind_n = ESC_PCT;
						cnt_n = 3'd0;
						if (last) begin
							if (cfg.permit_bad_escape) begin
								cmd.pfx_en = 1'b1;
								kind_n = ESC_NONE;
							end else begin
								fail = 1'b1;
							end
						end
					end else begin
						cmd.tail = classify({8'h00, b}, 1'b0, cfg);
					end
				end
				ESC_PCT: begin
					if ((cfg.unicode_mode && b == CH_U) || b_hex) begin
						buf_n[0] = b;
						cnt_n = 3'd1;
						kind_n = b_hex ? ESC_HEX : ESC_UNI;
						if (last) begin
							if (cfg.permit_bad_escape) begin
								cmd.pfx_en = 1'b1;
								cmd.pfx_cnt = 3'd1;
								cmd.pfx_bytes[0] = b;
								kind_n = ESC_NONE;
								cnt_n = 3'd0;
							end else begin
								fail = 1'b1;
							end
						end
					end else begin
						brk = 1'b1;
					end
				end
				ESC_HEX: begin
					if (b_hex) begin
						cmd.value = {8'h00, hex_val(buf_q[0]), b_val};
						cmd.tail = classify(cmd.value, 1'b1, cfg);
						kind_n = ESC_NONE;
						cnt_n = 3'd0;
					end else begin
						brk = 1'b1;
					end
				end
				ESC_UNI: begin
					if (b_hex) begin
						if (cnt_q == 3'd4) begin
							cmd.value = {hex_val(buf_q[1]), hex_val(buf_q[2]),
								hex_val(buf_q[3]), b_val};
							cmd.tail = classify(cmd.value, 1'b1, cfg);
							kind_n = ESC_NONE;
							cnt_n = 3'd0;
						end else begin
							buf_n[cnt_q[1:0]] = b;
							cnt_n = cnt_q + 3'd1;
							if (last) begin
								if (cfg.permit_bad_escape) begin
									cmd.pfx_en = 1'b1;
									cmd.pfx_cnt = cnt_q + 3'd1;
									cmd.pfx_bytes[cnt_q[1:0]] = b;
									kind_n = ESC_NONE;
									cnt_n = 3'd0;
								end else begin
									fail = 1'b1;
								end
							end
						end
					end else begin
						brk = 1'b1;
					end
				end
				default: begin
					kind_n = ESC_NONE;
					cnt_n = 3'd0;
				end
			endcase
			// broken escape: fail unless bad escapes are permitted, else replay the held bytes and treat the byte as fresh
			if (brk) begin
				if (!cfg.permit_bad_escape) begin
					fail = 1'b1;
				end else begin
					cmd.pfx_en = 1'b1;
					cmd.pfx_cnt = cnt_q;
					kind_n = ESC_NONE;
					cnt_n = 3'd0;
					if (b == CH_PCT) begin
						if (last) begin
							cmd.tail = TAIL_PCT;
						end else begin
							kind_n = ESC_PCT;
						end
					end else begin
						cmd.value = {8'h00, b};
						cmd.tail = classify({8'h00, b}, 1'b0, cfg);
					end
				end
			end
			if (fail) begin
				cmd.pfx_en = 1'b0;
				cmd.tail = TAIL_FAIL;
				cmd.value = 16'h0000;
				kind_n = ESC_NONE;
				cnt_n = 3'd0;
				disc_n = !last;
			end
		end
	end

	assign cmd_valid = accept && !disc_q && (cmd.pfx_en || cmd.tail != TAIL_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= ESC_NONE;
			cnt_q <= 3'd0;
			disc_q <= 1'b0;
		end else if (accept) begin
			kind_q <= kind_n;
			cnt_q <= cnt_n;
			disc_q <= disc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= buf_n;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == ESC_NONE || kind_q == ESC_PCT) |-> cnt_q == 3'd0)
		else $error("escape count set with no held bytes");
	a_hex_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == ESC_HEX) |-> cnt_q == 3'd1)
		else $error("two-digit escape must hold exactly one byte");
	a_uni_count: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == ESC_UNI) |-> (cnt_q != 3'd0 && cnt_q <= 3'd4))
		else $error("wide escape count out of range");
	a_disc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> kind_q == ESC_NONE)
		else $error("escape pending while discarding");
`endif

endmodule

FILE: design/uec_queue.sv
// short command queue between the front end and the back end
// depends on uec_pkg
module uec_queue #(
	parameter int QUEUE_DEPTH = uec_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input uec_pkg::cmd_t in_cmd,
	output logic out_valid,
	input logic out_ready,
	output uec_pkg::cmd_t out_cmd
);
	import uec_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign in_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_ready)
		else $error("command offered while queue full");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> rd_ptr_q == wr_ptr_q)
		else $error("empty queue with unequal pointers");
`endif

endmodule

FILE: design/uec_back.sv
// back end: expands each command into output characters, one beat per cycle while the output is ready
// depends on uec_pkg and uec_out_if
module uec_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input uec_pkg::cmd_t cmd,
	uec_out_if.source out_ch
);
	import uec_pkg::*;

	cmd_t cmd_q;
	logic busy_q;
	logic [3:0] pos_q;
	logic out_valid_q;
	logic [7:0] char_q;
	logic last_q;
	logic err_q;

	logic [3:0] pfx_len;
	logic [3:0] tail_len;
	logic [3:0] total_len;
	logic [3:0] tpos;
	logic [3:0] pidx;
	logic final_beat;
	logic advance;
	logic [7:0] char_n;
	logic err_n;
	logic last_n;

	assign pfx_len = cmd_q.pfx_en ? {1'b0, cmd_q.pfx_cnt} + 4'd1 : 4'd0;

	always_comb begin
		case (cmd_q.tail)
			TAIL_PLAIN, TAIL_PCT, TAIL_FAIL: tail_len = 4'd1;
			TAIL_ESC: tail_len = 4'd3;
			TAIL_WIDE: tail_len = 4'd6;
			default: tail_len = 4'd0;
		endcase
	end

	assign total_len = pfx_len + tail_len;
	assign tpos = pos_q - pfx_len;
	assign pidx = pos_q - 4'd1;
	assign final_beat = pos_q == total_len - 4'd1;

	always_comb begin
		char_n = 8'h00;
		err_n = 1'b0;
		if (pos_q < pfx_len) begin
			char_n = (pos_q == 4'd0) ? CH_PCT : cmd_q.pfx_bytes[pidx[1:0]];
		end else begin
			case (cmd_q.tail)
				TAIL_PLAIN: char_n = cmd_q.value[7:0];
				TAIL_PCT: char_n = CH_PCT;
				TAIL_FAIL: err_n = 1'b1;
				TAIL_ESC: begin
					case (tpos)
						4'd0: char_n = CH_PCT;
						4'd1: char_n = hex_char(cmd_q.value[7:4]);
						default: char_n = hex_char(cmd_q.value[3:0]);
					endcase
				end
				TAIL_WIDE: begin
					case (tpos)
						4'd0: char_n = CH_PCT;
						4'd1: char_n = CH_U;
						4'd2: char_n = hex_char(cmd_q.value[15:12]);
						4'd3: char_n = hex_char(cmd_q.value[11:8]);
						4'd4: char_n = hex_char(cmd_q.value[7:4]);
						default: char_n = hex_char(cmd_q.value[3:0]);
					endcase
				end
				default: char_n = 8'h00;
			endcase
		end
	end

	assign last_n = final_beat && (cmd_q.last || cmd_q.tail == TAIL_FAIL);
	assign advance = busy_q && (!out_valid_q || out_ch.ready);
	// next command loads in the same cycle the current one sends its final beat
	assign cmd_ready = !busy_q || (advance && final_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				busy_q <= 1'b1;
				pos_q <= 4'd0;
			end else if (advance && final_beat) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				pos_q <= pos_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (advance) begin
			char_q <= char_n;
			last_q <= last_n;
			err_q <= err_n;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_char = char_q;
	assign out_ch.out_last = last_q;
	assign out_ch.out_error = err_q;

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q < total_len)
		else $error("beat position past end of command");
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (last_q && char_q == 8'h00))
		else $error("error beat must be a final zero character");
	a_fail_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cmd_q.tail == TAIL_FAIL) |-> !cmd_q.pfx_en)
		else $error("error command carries a replay prefix");
`endif

endmodule

FILE: design/url_escape_canonicalizer_core.sv
// url escape canonicalizer top level: apb register file, front end, command queue, back end
// path: a byte's command is queued, then the back end registers its characters
// throughput: one character per cycle leaves the back end while the output is ready;
// a byte yields 0 to 8 characters, and bytes enter every cycle while the queue has room
// reset: arst_n clears escape state, queue and output valid, and restores register defaults
// depends on uec_pkg, uec_if, uec_front, uec_queue and uec_back
module url_escape_canonicalizer_core #(
	parameter int QUEUE_DEPTH = uec_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	uec_in_if.sink in_ch,
	uec_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [uec_pkg::ADDR_W-1:0] paddr,
	input logic [uec_pkg::DATA_W-1:0] pwdata,
	output logic [uec_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import uec_pkg::*;

	cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qb_valid;
	logic qb_ready;
	cmd_t qb_cmd;

	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unicode_mode <= 1'b0;
			cfg_q.permit_bad_escape <= 1'b0;
			cfg_q.unsafe_mask_low <= MASK_LOW_RST;
			cfg_q.unsafe_mask_high <= MASK_HIGH_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_UNICODE_MODE: cfg_q.unicode_mode <= pwdata[0];
				REG_PERMIT_BAD: cfg_q.permit_bad_escape <= pwdata[0];
				REG_MASK_LOW: cfg_q.unsafe_mask_low <= pwdata;
				REG_MASK_HIGH: cfg_q.unsafe_mask_high <= pwdata[31:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_UNICODE_MODE: prdata = {63'd0, cfg_q.unicode_mode};
			REG_PERMIT_BAD: prdata = {63'd0, cfg_q.permit_bad_escape};
			REG_MASK_LOW: prdata = cfg_q.unsafe_mask_low;
			REG_MASK_HIGH: prdata = {32'd0, cfg_q.unsafe_mask_high};
			default: prdata = '0;
		endcase
	end

	uec_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg(cfg_q),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.cmd(fq_cmd)
	);

	uec_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_cmd(fq_cmd),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_cmd(qb_cmd)
	);

	uec_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd(qb_cmd),
		.out_ch(out_ch)
	);

endmodule
